@@ rtl/psdcu_pkg.sv @@
// ----------------------------------------------------------------------------
// psdcu_pkg
// Shared widths, defaults and register codes of the prefix-shared DT code
// unpacker.
// ----------------------------------------------------------------------------
package psdcu_pkg;

   localparam int BYTE_W  = 8;
   localparam int NIB_W   = 4;
   localparam int CC_W    = 5;    // crossing count register
   localparam int POS_W   = 4;
   localparam int ENTRY_W = 9;
   localparam int REC_W   = 24;
   localparam int CSR_W   = 24;   // widest register
   localparam int MIN_CROSSINGS = 3;

   localparam int MAX_CROSSINGS_DEF = 16;
   localparam int COUNT_WIDTH_DEF   = 24;

   typedef enum logic [1:0] {
      CSR_CROSSING_COUNT   = 2'd0,
      CSR_ALTERNATING_MODE = 2'd1,
      CSR_FIRST_RECORD     = 2'd2,
      CSR_FINAL_RECORD     = 2'd3
   } csr_index_type;

endpackage

@@ rtl/psdcu_if.sv @@
// ----------------------------------------------------------------------------
// psdcu channel interfaces
// Valid/ready channels for stream bytes, decoded entries and register writes.
// ----------------------------------------------------------------------------
interface psdcu_req_if;
   logic                              valid;
   logic                              ready;
   logic [psdcu_pkg::BYTE_W-1:0]      pack_byte;

   modport source (output valid, output pack_byte, input ready);
   modport sink   (input valid, input pack_byte, output ready);
endinterface

interface psdcu_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [psdcu_pkg::POS_W-1:0]       position;
   logic signed [psdcu_pkg::ENTRY_W-1:0] entry_value;
   logic [psdcu_pkg::REC_W-1:0]       record_number;
   logic                              last_entry;
   logic                              bad_header;

   modport source (output valid, output position, output entry_value,
                   output record_number, output last_entry, output bad_header,
                   input ready);
   modport sink   (input valid, input position, input entry_value,
                   input record_number, input last_entry, input bad_header,
                   output ready);
endinterface

interface psdcu_csr_if;
   logic                              valid;
   logic                              ready;
   psdcu_pkg::csr_index_type          index;
   logic [psdcu_pkg::CSR_W-1:0]       data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/psdcu_nib_mem.sv @@
// ----------------------------------------------------------------------------
// psdcu_nib_mem
// Code nibble store: one write port, one registered read port, per-entry
// valid bits so that entries never written read as zero after reset.
// ----------------------------------------------------------------------------
module psdcu_nib_mem #(
   parameter int DEPTH  = psdcu_pkg::MAX_CROSSINGS_DEF - 1,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [psdcu_pkg::NIB_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [psdcu_pkg::NIB_W-1:0] rd_data
);

   logic [psdcu_pkg::NIB_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]            valid_ff;
   logic [psdcu_pkg::NIB_W-1:0] rd_data_ff;
   logic                        rd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

@@ rtl/prefix_shared_dt_code_unpacker.sv @@
// ----------------------------------------------------------------------------
// prefix_shared_dt_code_unpacker
// Decodes a packed, prefix-shared DT code stream into signed code entries.
// ----------------------------------------------------------------------------
// Header and sign bytes are taken in ST_IDLE; a tail byte also passes through
// ST_TAIL_LO (one nibble write per cycle via the single code memory write port).
// A completed record in range emits one entry per clamped crossing count: each code
// entry takes ST_RD (memory read) then ST_DAT (output load); the last comes from ST_FIN.
// Bad headers are answered in the cycle after the byte is taken; a busy output holds off bytes.
// Sync reset: control state cleared, signs positive, memory marked empty.
module prefix_shared_dt_code_unpacker #(
   parameter int MAX_CROSSINGS = psdcu_pkg::MAX_CROSSINGS_DEF,
   parameter int COUNT_WIDTH   = psdcu_pkg::COUNT_WIDTH_DEF
) (
   input logic         clock,
   input logic         reset,
   psdcu_req_if.sink   req_ch,
   psdcu_rsp_if.source rsp_ch,
   psdcu_csr_if.sink   csr_ch
);

   localparam int IDX_W  = $clog2(MAX_CROSSINGS);
   localparam int DEPTH  = MAX_CROSSINGS - 1;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int SUM_W  = $clog2(DEPTH * 15 + 1);
   localparam int CALC_W = (SUM_W + 3 > psdcu_pkg::ENTRY_W + 1) ?
                           SUM_W + 3 : psdcu_pkg::ENTRY_W + 1;
   localparam int CMP_W  = (COUNT_WIDTH > psdcu_pkg::REC_W) ?
                           COUNT_WIDTH : psdcu_pkg::REC_W;
   localparam int CC_W   = psdcu_pkg::CC_W;
   localparam int NIB_W  = psdcu_pkg::NIB_W;
   localparam int ENTRY_W = psdcu_pkg::ENTRY_W;
   localparam logic [CC_W-1:0] MIN_CC = CC_W'(psdcu_pkg::MIN_CROSSINGS);
   localparam logic [CC_W-1:0] MAX_CC = CC_W'(MAX_CROSSINGS);

   typedef enum logic [2:0] {
      ST_IDLE, ST_TAIL_LO, ST_RD, ST_DAT, ST_FIN
   } state_type;

   typedef enum logic [1:0] {
      PH_HEADER, PH_TAIL, PH_SIGN_HI, PH_SIGN_LO
   } phase_type;

   // configuration
   logic [CC_W-1:0]            crossing_ff;
   logic                       alt_ff;
   logic [psdcu_pkg::REC_W-1:0] first_ff;
   logic [psdcu_pkg::REC_W-1:0] final_ff;

   // parser and emit state
   state_type                  state_ff;
   phase_type                  phase_ff;
   logic [IDX_W-1:0]           fill_ff;
   logic [NIB_W-1:0]           lo_nib_ff;
   logic [IDX_W-1:0]           idx_ff;
   logic [SUM_W-1:0]           sum_ff;
   logic [COUNT_WIDTH-1:0]     count_ff;
   logic [MAX_CROSSINGS-1:0]   sign_ff;

   // output register
   logic                       rsp_valid_ff;
   logic [psdcu_pkg::POS_W-1:0] pos_ff;
   logic [ENTRY_W-1:0]         val_ff;
   logic [psdcu_pkg::REC_W-1:0] rec_ff;
   logic                       last_ff;
   logic                       bad_ff;

   logic [CC_W-1:0]            cc_eff;
   logic [IDX_W-1:0]           codelen;
   logic [NIB_W-1:0]           hi_nib;
   logic [NIB_W-1:0]           lo_nib;
   logic                       out_free;
   logic                       req_fire;
   logic                       hdr_bad;
   logic                       tail_done;
   logic                       finish_now;
   logic                       to_sign;
   logic [IDX_W-1:0]           fill_hi;
   logic [IDX_W-1:0]           fill_lo;
   logic [COUNT_WIDTH-1:0]     rec_next;
   logic                       in_range;
   logic [psdcu_pkg::REC_W-1:0] rec_next_out;
   logic [psdcu_pkg::REC_W-1:0] rec_cur_out;
   logic                       mem_wr_en;
   logic [NIB_W-1:0]           mem_wr_data;
   logic [NIB_W-1:0]           nib_rd;
   logic [ENTRY_W-1:0]         mag;
   logic [ENTRY_W-1:0]         entry_norm;
   logic [CALC_W-1:0]          tri_sum;
   logic [CALC_W-1:0]          fin_calc;
   logic [ENTRY_W-1:0]         entry_fin;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         crossing_ff <= MIN_CC;
         alt_ff      <= 1'b1;
         first_ff    <= '0;
         final_ff    <= '1;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            psdcu_pkg::CSR_CROSSING_COUNT:   crossing_ff <= csr_ch.data[CC_W-1:0];
            psdcu_pkg::CSR_ALTERNATING_MODE: alt_ff      <= csr_ch.data[0];
            psdcu_pkg::CSR_FIRST_RECORD:     first_ff    <= csr_ch.data;
            psdcu_pkg::CSR_FINAL_RECORD:     final_ff    <= csr_ch.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (crossing_ff < MIN_CC) begin
         cc_eff = MIN_CC;
      end else if (crossing_ff > MAX_CC) begin
         cc_eff = MAX_CC;
      end else begin
         cc_eff = crossing_ff;
      end
   end

   assign codelen  = IDX_W'(cc_eff - CC_W'(1));
   assign hi_nib   = req_ch.pack_byte[7:4];
   assign lo_nib   = req_ch.pack_byte[3:0];
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE) && out_free;
   assign req_fire = req_ch.valid && req_ch.ready;

   assign hdr_bad = (hi_nib != lo_nib) || (CC_W'(hi_nib) > CC_W'(codelen));
   assign fill_hi = fill_ff + IDX_W'(fill_ff < codelen);
   assign fill_lo = fill_ff + IDX_W'(fill_ff < codelen);

   // end of the tail: zero-length header or second nibble of the last byte
   always_comb begin
      tail_done = 1'b0;
      if (state_ff == ST_IDLE && req_fire && phase_ff == PH_HEADER &&
          !hdr_bad && hi_nib == '0) begin
         tail_done = 1'b1;
      end
      if (state_ff == ST_TAIL_LO && fill_lo >= codelen) begin
         tail_done = 1'b1;
      end
   end

   assign finish_now = (tail_done && alt_ff) ||
                       (state_ff == ST_IDLE && req_fire && phase_ff == PH_SIGN_LO);
   assign to_sign    = tail_done && !alt_ff;

   assign rec_next     = count_ff + COUNT_WIDTH'(1);
   assign in_range     = (CMP_W'(rec_next) >= CMP_W'(first_ff)) &&
                         (CMP_W'(rec_next) <= CMP_W'(final_ff));
   assign rec_next_out = psdcu_pkg::REC_W'(CMP_W'(rec_next));
   assign rec_cur_out  = psdcu_pkg::REC_W'(CMP_W'(count_ff));

   // nibble writes: high nibble as the byte is taken, low nibble in the next cycle (ST_TAIL_LO)
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_data = hi_nib;
      if (state_ff == ST_IDLE && req_fire && phase_ff == PH_TAIL) begin
         mem_wr_en = fill_ff < codelen;
      end
      if (state_ff == ST_TAIL_LO) begin
         mem_wr_en   = fill_ff < codelen;
         mem_wr_data = lo_nib_ff;
      end
   end

   psdcu_nib_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_nib_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_wr_en),
      .wr_addr (fill_ff[ADDR_W-1:0]),
      .wr_data (mem_wr_data),
      .rd_en   (state_ff == ST_RD),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (nib_rd)
   );

   assign mag = ENTRY_W'({nib_rd, 1'b0}) + ENTRY_W'(2);
   assign entry_norm = (!alt_ff && !sign_ff[idx_ff]) ? ENTRY_W'(-mag) : mag;

   // last entry: 2*(codelen*(codelen+1)/2 - sum) + 2, two's complement
   assign tri_sum  = (CALC_W'(codelen) * (CALC_W'(codelen) + CALC_W'(1))) >> 1;
   assign fin_calc = ((tri_sum - CALC_W'(sum_ff)) << 1) + CALC_W'(2);
   assign entry_fin = (!alt_ff && !sign_ff[codelen]) ?
                      ENTRY_W'(-fin_calc) : ENTRY_W'(fin_calc);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_HEADER;
         fill_ff      <= '0;
         idx_ff       <= '0;
         sum_ff       <= '0;
         count_ff     <= '0;
         sign_ff      <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  unique case (phase_ff)
                     PH_HEADER: begin
                        if (hdr_bad) begin
                           rsp_valid_ff <= 1'b1;
                           pos_ff       <= '0;
                           val_ff       <= '0;
                           rec_ff       <= rec_next_out;
                           last_ff      <= 1'b0;
                           bad_ff       <= 1'b1;
                        end else begin
                           fill_ff <= codelen - IDX_W'(hi_nib);
                           if (hi_nib != '0) begin
                              phase_ff <= PH_TAIL;
                           end
                        end
                     end
                     PH_TAIL: begin
                        fill_ff   <= fill_hi;
                        lo_nib_ff <= lo_nib;
                        state_ff  <= ST_TAIL_LO;
                     end
                     PH_SIGN_HI, PH_SIGN_LO: begin
                        for (int p = 0; p < MAX_CROSSINGS; p++) begin
                           if (CC_W'(p) < cc_eff &&
                               ((phase_ff == PH_SIGN_HI && p < 8) ||
                                (phase_ff == PH_SIGN_LO && p >= 8 && p < 16))) begin
                              sign_ff[p] <= req_ch.pack_byte[3'(7 - (p % 8))];
                           end
                        end
                        phase_ff <= PH_SIGN_LO;
                     end
                     default: ;
                  endcase
               end
            end
            ST_TAIL_LO: begin
               fill_ff  <= fill_lo;
               state_ff <= ST_IDLE;
            end
            ST_RD: begin
               state_ff <= ST_DAT;
            end
            ST_DAT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  pos_ff       <= psdcu_pkg::POS_W'(idx_ff);
                  val_ff       <= entry_norm;
                  rec_ff       <= rec_cur_out;
                  last_ff      <= 1'b0;
                  bad_ff       <= 1'b0;
                  sum_ff       <= sum_ff + SUM_W'(nib_rd);
                  idx_ff       <= idx_ff + IDX_W'(1);
                  state_ff     <= (idx_ff + IDX_W'(1) == codelen) ? ST_FIN : ST_RD;
               end
            end
            ST_FIN: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  pos_ff       <= psdcu_pkg::POS_W'(codelen);
                  val_ff       <= entry_fin;
                  rec_ff       <= rec_cur_out;
                  last_ff      <= 1'b1;
                  bad_ff       <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase

         if (to_sign) begin
            phase_ff <= PH_SIGN_HI;
         end
         // record complete: count it, then emit if the ordinal is in range
         if (finish_now) begin
            phase_ff <= PH_HEADER;
            fill_ff  <= '0;
            count_ff <= rec_next;
            idx_ff   <= '0;
            sum_ff   <= '0;
            state_ff <= in_range ? ST_RD : ST_IDLE;
         end
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.position      = pos_ff;
   assign rsp_ch.entry_value   = $signed(val_ff);
   assign rsp_ch.record_number = rec_ff;
   assign rsp_ch.last_entry    = last_ff;
   assign rsp_ch.bad_header    = bad_ff;

endmodule

@@ rtl/psdcu_checker.sv @@
// ----------------------------------------------------------------------------
// psdcu_checker
// Port-level checks on the result channel of the unpacker.
// ----------------------------------------------------------------------------
module psdcu_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [psdcu_pkg::POS_W-1:0]       rsp_position,
   input logic signed [psdcu_pkg::ENTRY_W-1:0] rsp_entry_value,
   input logic [psdcu_pkg::REC_W-1:0]       rsp_record_number,
   input logic                              rsp_last_entry,
   input logic                              rsp_bad_header
);

   // stalled transaction stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_position) &&
      $stable(rsp_entry_value) && $stable(rsp_record_number) &&
      $stable(rsp_last_entry) && $stable(rsp_bad_header))
      else $error("rsp transaction changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // DT entries are always even
   a_even: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_entry_value[0])
      else $error("odd entry value");

   a_bad_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_header |->
      rsp_position == '0 && rsp_entry_value == '0 && !rsp_last_entry)
      else $error("bad header transaction carries entry data");

endmodule

bind prefix_shared_dt_code_unpacker psdcu_checker u_psdcu_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_position      (rsp_ch.position),
   .rsp_entry_value   (rsp_ch.entry_value),
   .rsp_record_number (rsp_ch.record_number),
   .rsp_last_entry    (rsp_ch.last_entry),
   .rsp_bad_header    (rsp_ch.bad_header)
);

@@ tb/psdcu_dt_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// psdcu_dt_checker
// Watches the byte, entry and register channels of the DT code unpacker. It
// decodes the byte stream itself and compares every entry the block emits.
// ----------------------------------------------------------------------------
module psdcu_dt_checker (
   input  logic                        clock,
   input  logic                        reset,
   psdcu_req_if                        req_ch,
   psdcu_rsp_if                        rsp_ch,
   psdcu_csr_if                        csr_ch,
   output int                          mismatch_count,
   output int                          outstanding,
   output int                          results_checked,
   output logic [psdcu_pkg::REC_W-1:0] records_seen
);

   localparam int BYTE_W        = psdcu_pkg::BYTE_W;
   localparam int NIB_W         = psdcu_pkg::NIB_W;
   localparam int CC_W          = psdcu_pkg::CC_W;
   localparam int POS_W         = psdcu_pkg::POS_W;
   localparam int ENTRY_W       = psdcu_pkg::ENTRY_W;
   localparam int REC_W         = psdcu_pkg::REC_W;
   localparam int MIN_CROSSINGS = psdcu_pkg::MIN_CROSSINGS;
   localparam int MAX_CC        = psdcu_pkg::MAX_CROSSINGS_DEF;
   localparam int CODE_DEPTH    = MAX_CC - 1;
   localparam int REPORT_MAX    = 10;

   typedef enum logic [1:0] {
      WAIT_HEADER,
      READ_TAIL,
      READ_SIGN_HI,
      READ_SIGN_LO
   } parse_state_type;

   typedef struct packed {
      logic [POS_W-1:0]          position;
      logic signed [ENTRY_W-1:0] entry_value;
      logic [REC_W-1:0]          record_number;
      logic                      last_entry;
      logic                      bad_header;
   } dt_entry_type;

   logic [CC_W-1:0]  cfg_crossings;
   logic             cfg_alternating;
   logic [REC_W-1:0] cfg_first;
   logic [REC_W-1:0] cfg_final;

   logic [NIB_W-1:0] nibble_mem [CODE_DEPTH];
   logic             sign_mem [MAX_CC];
   logic [REC_W-1:0] rec_count;
   parse_state_type  parse_state;
   int unsigned      fill_idx;

   dt_entry_type expected_entries [$];

   assign records_seen = rec_count;

   function automatic int unsigned crossings_used();
      int unsigned c;
      c = 32'(cfg_crossings);
      if (c < MIN_CROSSINGS) c = MIN_CROSSINGS;
      if (c > MAX_CC) c = MAX_CC;
      return c;
   endfunction

   function automatic void push_entry(int unsigned pos, int value, logic [REC_W-1:0] rec,
                                      logic last, logic bad);
      dt_entry_type e;
      e.position      = pos[POS_W-1:0];
      e.entry_value   = value[ENTRY_W-1:0];
      e.record_number = rec;
      e.last_entry    = last;
      e.bad_header    = bad;
      expected_entries.push_back(e);
   endfunction

   function automatic void close_record();
      int unsigned len;
      int unsigned sum;
      int          v;
      len = crossings_used() - 1;
      sum = 0;
      parse_state = WAIT_HEADER;
      fill_idx = 0;
      rec_count = rec_count + 1'b1;
      if (rec_count < cfg_first || rec_count > cfg_final) return;
      for (int unsigned i = 0; i < len; i++) begin
         v = 2 * int'(nibble_mem[i]) + 2;
         if (!cfg_alternating && !sign_mem[i]) v = -v;
         sum += 32'(nibble_mem[i]);
         push_entry(i, v, rec_count, 1'b0, 1'b0);
      end
      // closing entry balances the triangular sum of the stored nibbles
      v = 2 * (int'(len * (len + 1) / 2) - int'(sum)) + 2;
      if (!cfg_alternating && !sign_mem[len]) v = -v;
      push_entry(len, v, rec_count, 1'b1, 1'b0);
   endfunction

   function automatic void load_signs(logic [BYTE_W-1:0] b, int unsigned base);
      int unsigned cc;
      cc = crossings_used();
      for (int unsigned q = 0; q < 8; q++)
         if (base + q < cc) sign_mem[base + q] = b[7 - q];
   endfunction

   function automatic void end_of_tail();
      if (cfg_alternating) close_record();
      else parse_state = READ_SIGN_HI;
   endfunction

   function automatic void decode_byte(logic [BYTE_W-1:0] b);
      logic [NIB_W-1:0] hi;
      logic [NIB_W-1:0] lo;
      int unsigned      len;
      hi  = b[7:4];
      lo  = b[3:0];
      len = crossings_used() - 1;
      case (parse_state)
         WAIT_HEADER: begin
            if (hi != lo || 32'(hi) > len) begin
               push_entry(0, 0, rec_count + 1'b1, 1'b0, 1'b1);
            end else begin
               fill_idx = len - 32'(hi);
               if (hi == '0) end_of_tail();
               else parse_state = READ_TAIL;
            end
         end
         READ_TAIL: begin
            if (fill_idx < len) begin
               nibble_mem[fill_idx] = hi;
               fill_idx = fill_idx + 1;
            end
            if (fill_idx < len) begin
               nibble_mem[fill_idx] = lo;
               fill_idx = fill_idx + 1;
            end
            fill_idx &= 32'hF;
            if (fill_idx >= len) end_of_tail();
         end
         READ_SIGN_HI: begin
            load_signs(b, 0);
            parse_state = READ_SIGN_LO;
         end
         READ_SIGN_LO: begin
            load_signs(b, 8);
            close_record();
         end
      endcase
   endfunction

   function automatic void log_mismatch(string note, dt_entry_type want, logic have_want);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX) begin
         if (have_want)
            $display("%s: expected pos %0d val %0d rec %0d last %0b bad %0b", note,
                     want.position, $signed(want.entry_value), want.record_number,
                     want.last_entry, want.bad_header);
         $display("%s: got pos %0d val %0d rec %0d last %0b bad %0b at %0t", note,
                  rsp_ch.position, $signed(rsp_ch.entry_value), rsp_ch.record_number,
                  rsp_ch.last_entry, rsp_ch.bad_header, $realtime);
      end
   endfunction

   always @(posedge clock) begin
      dt_entry_type want;
      if (reset) begin
         cfg_crossings   = CC_W'(MIN_CROSSINGS);
         cfg_alternating = 1'b1;
         cfg_first       = '0;
         cfg_final       = '1;
         foreach (nibble_mem[i]) nibble_mem[i] = '0;
         foreach (sign_mem[i]) sign_mem[i] = 1'b1;
         rec_count       = '0;
         parse_state     = WAIT_HEADER;
         fill_idx        = 0;
         expected_entries.delete();
         mismatch_count  = 0;
         results_checked = 0;
      end else begin
         // output transaction first: nothing answers a byte in its own cycle
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_entries.size() == 0) begin
               want = '0;
               log_mismatch("unexpected entry", want, 1'b0);
            end else begin
               want = expected_entries.pop_front();
               results_checked++;
               if (rsp_ch.position !== want.position ||
                   rsp_ch.entry_value !== want.entry_value ||
                   rsp_ch.record_number !== want.record_number ||
                   rsp_ch.last_entry !== want.last_entry ||
                   rsp_ch.bad_header !== want.bad_header)
                  log_mismatch("entry mismatch", want, 1'b1);
            end
         end
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               psdcu_pkg::CSR_CROSSING_COUNT:   cfg_crossings   = csr_ch.data[CC_W-1:0];
               psdcu_pkg::CSR_ALTERNATING_MODE: cfg_alternating = csr_ch.data[0];
               psdcu_pkg::CSR_FIRST_RECORD:     cfg_first       = csr_ch.data[REC_W-1:0];
               psdcu_pkg::CSR_FINAL_RECORD:     cfg_final       = csr_ch.data[REC_W-1:0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) decode_byte(req_ch.pack_byte);
      end
      outstanding = expected_entries.size();
   end

endmodule

@@ tb/tb_prefix_shared_dt_code_unpacker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_prefix_shared_dt_code_unpacker
// Feeds packed DT code streams into the unpacker: a directed set of headers,
// tails and sign bytes, then random records, bad headers and noise under
// several register settings and idling patterns. The checker beside the block
// predicts and compares every entry.
// ----------------------------------------------------------------------------
module tb_prefix_shared_dt_code_unpacker;

   localparam int REC_W         = psdcu_pkg::REC_W;
   localparam int CSR_W         = psdcu_pkg::CSR_W;
   localparam int CC_W          = psdcu_pkg::CC_W;
   localparam int MIN_CROSSINGS = psdcu_pkg::MIN_CROSSINGS;
   localparam int MAX_CC        = psdcu_pkg::MAX_CROSSINGS_DEF;

   localparam int STALL_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_STRETCH  = 250;
   localparam int PHASE_ITEMS   = 54;
   localparam int EMPTY_ITEMS   = 22;

   // reset settings: zero tail, max nibbles, unequal header, oversized tail, odd tail
   localparam logic [7:0] DIR_A [7] = '{8'h00, 8'h22, 8'hFF, 8'h12, 8'h33, 8'h11, 8'hA5};
   // 16 crossings with signs: full tail, all negative; zero tail, all positive;
   // then a record left open in its tail
   localparam logic [7:0] DIR_B [16] = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                         8'hFF, 8'hF0, 8'h00, 8'h00,
                                         8'h00, 8'hFF, 8'hFF,
                                         8'h77, 8'h00};
   // crossing count shrunk inside that record: the tail closes at once
   localparam logic [7:0] DIR_C [3] = '{8'h00, 8'h5A, 8'hC3};

   localparam int TX_IDLE  [4] = '{0, 54, 0, 15};
   localparam int RX_STALL [4] = '{0, 0, 54, 15};

   logic clock = 1'b0;
   logic reset;

   always #5 clock = ~clock;

   psdcu_req_if req_if ();
   psdcu_rsp_if rsp_if ();
   psdcu_csr_if csr_if ();

   int               mismatch_count;
   int               outstanding;
   int               results_checked;
   logic [REC_W-1:0] records_seen;

   int          tx_idle_pct;
   int          rx_stall_pct;
   int          hold_cycles;
   int          idle_cycles;
   int          bytes_sent;
   int          settings_used;
   int unsigned cur_cc;
   logic        cur_alt;

   prefix_shared_dt_code_unpacker DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   psdcu_dt_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_if),
      .rsp_ch          (rsp_if),
      .csr_ch          (csr_if),
      .mismatch_count  (mismatch_count),
      .outstanding     (outstanding),
      .results_checked (results_checked),
      .records_seen    (records_seen)
   );

   // receiver: random stalls, or a counted hold-off when one is requested
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_if.ready <= 1'b0;
         hold_cycles  <= hold_cycles - 1;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // watchdog: cycles without any transaction on any channel
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_prefix_shared_dt_code_unpacker failed");
         $finish;
      end
   end

   function automatic int unsigned code_len();
      int unsigned c;
      c = cur_cc;
      if (c < MIN_CROSSINGS) c = MIN_CROSSINGS;
      if (c > MAX_CC) c = MAX_CC;
      return c - 1;
   endfunction

   // called at a falling edge, returns at a falling edge; valid stays up
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.pack_byte <= b;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic write_reg(input psdcu_pkg::csr_index_type idx,
                            input logic [CSR_W-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_config(input int unsigned cc, input logic alt,
                             input logic [REC_W-1:0] lo_rec, input logic [REC_W-1:0] hi_rec);
      write_reg(psdcu_pkg::CSR_CROSSING_COUNT, CSR_W'(cc[CC_W-1:0]));
      write_reg(psdcu_pkg::CSR_ALTERNATING_MODE, CSR_W'(alt));
      write_reg(psdcu_pkg::CSR_FIRST_RECORD, CSR_W'(lo_rec));
      write_reg(psdcu_pkg::CSR_FINAL_RECORD, CSR_W'(hi_rec));
      csr_if.valid <= 1'b0;
      cur_cc  = 32'(cc[CC_W-1:0]);
      cur_alt = alt;
      settings_used++;
   endtask

   // stop offering bytes, wait for every pending entry, then let the block settle
   task automatic drain();
      req_if.valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic send_record();
      int unsigned len;
      int unsigned t;
      logic [3:0]  tn;
      len = code_len();
      t   = $urandom_range(len, 0);
      tn  = t[3:0];
      send_byte({tn, tn});
      for (int unsigned k = 0; k < (t + 1) / 2; k++) send_byte(8'($urandom_range(255)));
      if (!cur_alt) begin
         send_byte(8'($urandom_range(255)));
         send_byte(8'($urandom_range(255)));
      end
   endtask

   task automatic send_bad_header();
      int unsigned len;
      logic [3:0]  hi;
      logic [3:0]  lo;
      len = code_len();
      hi  = 4'($urandom_range(15));
      if (len < 15 && $urandom_range(1) == 1) begin
         hi = 4'($urandom_range(15, len + 1));
         lo = hi;
      end else begin
         lo = hi ^ 4'($urandom_range(15, 1));
      end
      send_byte({hi, lo});
   endtask

   task automatic run_random(input int n);
      int start;
      int pick;
      start = bytes_sent;
      while (bytes_sent - start < n) begin
         pick = $urandom_range(99);
         if (pick < 72) send_record();
         else if (pick < 86) send_bad_header();
         else send_byte(8'($urandom_range(255)));
      end
   endtask

   initial begin
      logic [REC_W-1:0] base;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.pack_byte = '0;
      rsp_if.ready     = 1'b0;
      csr_if.valid     = 1'b0;
      csr_if.index     = psdcu_pkg::CSR_CROSSING_COUNT;
      csr_if.data      = '0;
      tx_idle_pct      = 0;
      rx_stall_pct     = 0;
      hold_cycles      = 0;
      bytes_sent       = 0;
      settings_used    = 0;
      cur_cc           = MIN_CROSSINGS;
      cur_alt          = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIR_A[i]) send_byte(DIR_A[i]);
      drain();
      set_config(MAX_CC, 1'b0, '0, '1);
      foreach (DIR_B[i]) send_byte(DIR_B[i]);
      drain();
      set_config(5, 1'b0, '0, '1);
      foreach (DIR_C[i]) send_byte(DIR_C[i]);

      for (int p = 0; p < 4; p++) begin
         drain();
         base = records_seen;
         case (p)
            0: set_config(MAX_CC, 1'b1, '0, '1);
            1: set_config($urandom_range(31, 0), 1'b0, base + REC_W'(2),
                          base + REC_W'(2) + REC_W'($urandom_range(200, 60)));
            2: set_config($urandom_range(16, 3), 1'($urandom_range(1)), '0, '1);
            default: set_config($urandom_range(1) ? $urandom_range(2, 0) : $urandom_range(31, 17),
                                1'b0, base + REC_W'(1),
                                base + REC_W'(1) + REC_W'($urandom_range(300, 100)));
         endcase
         tx_idle_pct  = TX_IDLE[p];
         rx_stall_pct = RX_STALL[p];
         // long receiver hold-off while bytes keep coming: the block must back up
         if (p == 0) hold_cycles = HOLD_STRETCH;
         run_random(PHASE_ITEMS);
         if (p == 2) begin
            drain();
            set_config(cur_cc, cur_alt, '1, '0);
            run_random(EMPTY_ITEMS);
         end
      end

      drain();
      $display("covered %0d stream bytes, %0d records, %0d entries checked", bytes_sent,
               records_seen, results_checked);
      $display("under %0d register settings and four idling patterns", settings_used);
      if (mismatch_count == 0 && outstanding == 0)
         $display("tb_prefix_shared_dt_code_unpacker passed");
      else
         $display("tb_prefix_shared_dt_code_unpacker failed");
      $finish;
   end

endmodule
